### rtl/generational_handle_allocator_unit_assert.svh
// Assertion shorthands for the allocator RTL.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_UNIT_ASSERT_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_UNIT_ASSERT_SVH

// Condition must hold at every clock edge out of reset.
`define GHAU_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("ghau: invariant violated");

// Consequent must hold in the same cycle as the antecedent.
`define GHAU_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ghau: implication violated");

// Consequent must hold in the cycle after the antecedent.
`define GHAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ghau: next-cycle check violated");

`endif

### rtl/ghau_pkg.sv
package ghau_pkg;

    // Default configuration
    localparam int SLOTS_DEF    = 1024;
    localparam int GEN_BITS_DEF = 24;
    localparam int REF_BITS_DEF = 16;

    // Fixed field widths
    localparam int TAG_W    = 34;
    localparam int ACTION_W = 2;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 3;
    localparam int LIVE_W   = 11;

    // Actions
    localparam logic [ACTION_W-1:0] ACT_ALLOC   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_CHECK   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_ADD_REF = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd3;

    // Slot kinds
    localparam logic [KIND_W-1:0] KIND_FREE    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SHAPE   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ENTITY  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_HISTORY = 3'd3;
    localparam logic [KIND_W-1:0] KIND_MESH    = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK             = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID        = 3'd1;
    localparam logic [STATUS_W-1:0] ST_WRONG_KIND     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_RELEASABLE = 3'd4;
    localparam logic [STATUS_W-1:0] ST_SATURATED      = 3'd5;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [KIND_W-1:0]   kind;
        logic [TAG_W-1:0]    handle_tag;
    } t_in_word;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TAG_W-1:0]    new_tag;
        logic                slot_freed;
        logic [LIVE_W-1:0]   live_handles;
    } t_out_word;

    // Free stack controls
    typedef struct packed {
        logic rd;
        logic push;
        logic pop;
    } t_stack_ctl;

endpackage

### rtl/ghau_slot_store.sv
// Slot table: kind, reference count and generation per slot, one read and one write port.
module ghau_slot_store #(
    parameter int SLOTS    = ghau_pkg::SLOTS_DEF,
    parameter int GEN_BITS = ghau_pkg::GEN_BITS_DEF,
    parameter int REF_BITS = ghau_pkg::REF_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rd_en,
    input  logic [$clog2(SLOTS)-1:0]    i_rd_idx,
    output logic [ghau_pkg::KIND_W-1:0] o_rd_kind,
    output logic [REF_BITS-1:0]         o_rd_ref,
    output logic [GEN_BITS-1:0]         o_rd_gen,
    input  logic                        i_wr_en,
    input  logic [$clog2(SLOTS)-1:0]    i_wr_idx,
    input  logic [ghau_pkg::KIND_W-1:0] i_wr_kind,
    input  logic [REF_BITS-1:0]         i_wr_ref,
    input  logic [GEN_BITS-1:0]         i_wr_gen
);

    localparam int ENTRY_W = ghau_pkg::KIND_W + REF_BITS + GEN_BITS;

    logic [ENTRY_W-1:0] mem [SLOTS];
    logic [ENTRY_W-1:0] r_rd_q;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_idx] <= {i_wr_kind, i_wr_ref, i_wr_gen};
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_q <= mem[i_rd_idx];
        end
    end

    assign o_rd_kind = r_rd_q[ENTRY_W-1 -: ghau_pkg::KIND_W];
    assign o_rd_ref  = r_rd_q[GEN_BITS +: REF_BITS];
    assign o_rd_gen  = r_rd_q[GEN_BITS-1:0];

endmodule

### rtl/ghau_free_stack.sv
// LIFO of freed slot indexes, with its depth counter.
module ghau_free_stack #(
    parameter int SLOTS = ghau_pkg::SLOTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ghau_pkg::t_stack_ctl         i_ctl,
    input  logic [$clog2(SLOTS)-1:0]     i_push_idx,
    output logic [$clog2(SLOTS+1)-1:0]   o_depth,
    output logic [$clog2(SLOTS)-1:0]     o_top_idx
);

    localparam int IW = $clog2(SLOTS);
    localparam int LW = $clog2(SLOTS + 1);

    logic [IW-1:0] mem [SLOTS];
    logic [IW-1:0] r_top_q;
    logic [LW-1:0] r_depth;
    logic [LW-1:0] w_top_addr;
    logic          w_push_ok;

    assign w_top_addr = r_depth - 1'b1;
    assign w_push_ok  = i_ctl.push && (r_depth < LW'(SLOTS));

    // Depth counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else if (w_push_ok) begin
            r_depth <= r_depth + 1'b1;
        end else if (i_ctl.pop) begin
            r_depth <= r_depth - 1'b1;
        end
    end

    // Push writes at the current depth
    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            mem[r_depth[IW-1:0]] <= i_push_idx;
        end
    end

    // Registered read of the top entry
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_top_q <= mem[w_top_addr[IW-1:0]];
        end
    end

    assign o_depth   = r_depth;
    assign o_top_idx = r_top_q;

endmodule

### rtl/generational_handle_allocator_unit.sv
// Flow: accept, then the execute state registers the result; an allocation that
// reuses a freed slot adds a pop state (free stack read, then slot read).
// Input: a new word is taken only after the last has committed, which output stall can
// hold off; reads and write-backs on the single slot port pair never overlap.
// Reset: counters and control clear; slots at and above the fresh mark read
// as free with generation zero, so no clearing pass is run.
`include "generational_handle_allocator_unit_assert.svh"

module generational_handle_allocator_unit #(
    parameter int SLOTS    = ghau_pkg::SLOTS_DEF,
    parameter int GEN_BITS = ghau_pkg::GEN_BITS_DEF,
    parameter int REF_BITS = ghau_pkg::REF_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ghau_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ghau_pkg::t_out_word o_out_word
);

    localparam int IW = $clog2(SLOTS);
    localparam int LW = $clog2(SLOTS + 1);
    localparam int KW = ghau_pkg::KIND_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};

    // Control and request registers
    logic [1:0]                      r_state;
    logic [ghau_pkg::ACTION_W-1:0]   r_action;
    logic [KW-1:0]                   r_kind;
    logic [GEN_BITS-1:0]             r_tag_gen;
    logic [IW-1:0]                   r_idx;
    logic                            r_range_ok;
    logic                            r_use_mem;
    logic [LW-1:0]                   r_fresh_mark;
    logic [LW-1:0]                   r_live;
    logic                            r_out_valid;
    ghau_pkg::t_out_word             r_out;

    // Submodule connections
    ghau_pkg::t_stack_ctl            w_stack_ctl;
    logic [LW-1:0]                   w_depth;
    logic [IW-1:0]                   w_top_idx;
    logic                            w_slot_rd;
    logic [IW-1:0]                   w_slot_rd_idx;
    logic [KW-1:0]                   w_mem_kind;
    logic [REF_BITS-1:0]             w_mem_ref;
    logic [GEN_BITS-1:0]             w_mem_gen;
    logic                            w_wr_en;
    logic [KW-1:0]                   w_wr_kind;
    logic [REF_BITS-1:0]             w_wr_ref;
    logic [GEN_BITS-1:0]             w_wr_gen;

    // Front-end decode
    logic                            w_accept;
    logic                            w_is_alloc;
    logic [ghau_pkg::TAG_W-1:0]      w_tag_idx;
    logic                            w_tag_range_ok;
    logic                            w_commit;

    // Execute-stage values
    logic [KW-1:0]                   s_kind;
    logic [REF_BITS-1:0]             s_ref;
    logic [GEN_BITS-1:0]             s_gen;
    logic [GEN_BITS-1:0]             w_alloc_gen;
    logic [GEN_BITS-1:0]             w_bump_gen;
    logic [63:0]                     w_tag64;
    logic                            w_kind_ok;
    logic [ghau_pkg::STATUS_W-1:0]   n_status;
    logic [ghau_pkg::TAG_W-1:0]      n_new_tag;
    logic                            n_freed;
    logic                            n_wr;
    logic                            n_push;
    logic                            n_pop;
    logic                            n_mark_inc;
    logic [LW-1:0]                   n_live;

    assign w_accept       = i_in_valid && (r_state == S_IDLE);
    assign w_is_alloc     = (i_in_word.action == ghau_pkg::ACT_ALLOC);
    assign w_tag_idx      = i_in_word.handle_tag >> GEN_BITS;
    assign w_tag_range_ok = (i_in_word.handle_tag != '0)
                          && (w_tag_idx < ghau_pkg::TAG_W'(r_fresh_mark))
                          && (w_tag_idx < ghau_pkg::TAG_W'(SLOTS));
    assign w_commit       = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);
    assign o_in_stall     = (r_state != S_IDLE);

    // Memory read requests: tag slot on accept, popped slot after the stack read
    always_comb begin
        w_stack_ctl.rd   = w_accept && w_is_alloc && (w_depth != '0);
        w_stack_ctl.push = w_commit && n_push;
        w_stack_ctl.pop  = w_commit && n_pop;
        w_slot_rd        = (w_accept && !w_is_alloc) || (r_state == S_POP);
        w_slot_rd_idx    = (r_state == S_POP) ? w_top_idx : w_tag_idx[IW-1:0];
    end

    ghau_free_stack #(
        .SLOTS(SLOTS)
    ) u_free_stack (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_stack_ctl),
        .i_push_idx (r_idx),
        .o_depth    (w_depth),
        .o_top_idx  (w_top_idx)
    );

    ghau_slot_store #(
        .SLOTS    (SLOTS),
        .GEN_BITS (GEN_BITS),
        .REF_BITS (REF_BITS)
    ) u_slot_store (
        .i_clk     (i_clk),
        .i_rd_en   (w_slot_rd),
        .i_rd_idx  (w_slot_rd_idx),
        .o_rd_kind (w_mem_kind),
        .o_rd_ref  (w_mem_ref),
        .o_rd_gen  (w_mem_gen),
        .i_wr_en   (w_wr_en),
        .i_wr_idx  (r_idx),
        .i_wr_kind (w_wr_kind),
        .i_wr_ref  (w_wr_ref),
        .i_wr_gen  (w_wr_gen)
    );

    // Fresh slots have never been written: they read as free, generation zero
    assign s_kind = r_use_mem ? w_mem_kind : ghau_pkg::KIND_FREE;
    assign s_ref  = r_use_mem ? w_mem_ref  : '0;
    assign s_gen  = r_use_mem ? w_mem_gen  : '0;

    assign w_kind_ok   = (r_kind >= ghau_pkg::KIND_SHAPE) && (r_kind <= ghau_pkg::KIND_MESH);
    // Slot 0 skips generation zero so that no tag is zero
    assign w_alloc_gen = ((r_idx == '0) && (s_gen == '0)) ? GEN_BITS'(1) : s_gen;
    assign w_bump_gen  = ((r_idx == '0) && ((s_gen + 1'b1) == '0)) ? GEN_BITS'(1)
                                                                    : GEN_BITS'(s_gen + 1'b1);
    assign w_tag64     = (64'(r_idx) << GEN_BITS) | 64'(w_alloc_gen);

    // Execute: validate, modify and pick the write-back
    always_comb begin
        n_status   = ghau_pkg::ST_OK;
        n_new_tag  = '0;
        n_freed    = 1'b0;
        n_wr       = 1'b0;
        n_push     = 1'b0;
        n_pop      = 1'b0;
        n_mark_inc = 1'b0;
        n_live     = r_live;
        w_wr_kind  = s_kind;
        w_wr_ref   = s_ref;
        w_wr_gen   = s_gen;
        if (r_action == ghau_pkg::ACT_ALLOC) begin
            if (!w_kind_ok) begin
                n_status = ghau_pkg::ST_WRONG_KIND;
            end else if ((w_depth != '0) || (r_fresh_mark < LW'(SLOTS))) begin
                n_wr       = 1'b1;
                w_wr_kind  = r_kind;
                w_wr_ref   = REF_BITS'(1);
                w_wr_gen   = w_alloc_gen;
                n_pop      = (w_depth != '0);
                n_mark_inc = (w_depth == '0);
                n_live     = r_live + 1'b1;
                n_new_tag  = w_tag64[ghau_pkg::TAG_W-1:0];
            end else begin
                n_status = ghau_pkg::ST_EXHAUSTED;
            end
        end else if (!(r_range_ok && (s_gen == r_tag_gen) && (s_kind != ghau_pkg::KIND_FREE)))
        begin
            n_status = ghau_pkg::ST_INVALID;
        end else if (s_kind != r_kind) begin
            n_status = ghau_pkg::ST_WRONG_KIND;
        end else begin
            case (r_action)
                ghau_pkg::ACT_ADD_REF: begin
                    if (r_kind != ghau_pkg::KIND_SHAPE) begin
                        n_status = ghau_pkg::ST_WRONG_KIND;
                    end else if (s_ref == REF_MAX) begin
                        n_status = ghau_pkg::ST_SATURATED;
                    end else begin
                        n_wr     = 1'b1;
                        w_wr_ref = s_ref + 1'b1;
                    end
                end
                ghau_pkg::ACT_RELEASE: begin
                    if (r_kind == ghau_pkg::KIND_ENTITY) begin
                        n_status = ghau_pkg::ST_NOT_RELEASABLE;
                    end else if ((r_kind == ghau_pkg::KIND_SHAPE) && (s_ref > REF_BITS'(1))) begin
                        n_wr     = 1'b1;
                        w_wr_ref = s_ref - 1'b1;
                    end else begin
                        // Free the slot and retire every older tag
                        n_wr      = 1'b1;
                        w_wr_kind = ghau_pkg::KIND_FREE;
                        w_wr_ref  = '0;
                        w_wr_gen  = w_bump_gen;
                        n_push    = 1'b1;
                        n_freed   = 1'b1;
                        if (r_live != '0) begin
                            n_live = r_live - 1'b1;
                        end
                    end
                end
                default: begin
                    // Check only validates
                end
            endcase
        end
    end

    assign w_wr_en = w_commit && n_wr;

    // Sequencer and request capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= (w_is_alloc && (w_depth != '0)) ? S_POP : S_EXEC;
                    end
                end
                S_POP: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (w_commit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action   <= i_in_word.action;
            r_kind     <= i_in_word.kind;
            r_tag_gen  <= i_in_word.handle_tag[GEN_BITS-1:0];
            r_range_ok <= w_tag_range_ok;
            r_use_mem  <= !w_is_alloc || (w_depth != '0);
            r_idx      <= w_is_alloc ? r_fresh_mark[IW-1:0] : w_tag_idx[IW-1:0];
        end else if (r_state == S_POP) begin
            r_idx <= w_top_idx;
        end
    end

    // Table counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fresh_mark <= '0;
            r_live       <= '0;
        end else if (w_commit) begin
            if (n_mark_inc) begin
                r_fresh_mark <= r_fresh_mark + 1'b1;
            end
            r_live <= n_live;
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out.status       <= n_status;
            r_out.new_tag      <= n_new_tag;
            r_out.slot_freed   <= n_freed;
            r_out.live_handles <= ghau_pkg::LIVE_W'(n_live);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // Every slot below the fresh mark is either live or on the free stack
    `GHAU_ASSERT_ALWAYS(a_count_balance, i_clk, i_rst_n, ((LW+1)'(r_live) + (LW+1)'(w_depth)) == (LW+1)'(r_fresh_mark))
    `GHAU_ASSERT_ALWAYS(a_mark_bound, i_clk, i_rst_n, r_fresh_mark <= LW'(SLOTS))
    `GHAU_ASSERT_NEXT(a_commit_shows, i_clk, i_rst_n, w_commit, o_out_valid)
    `GHAU_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, w_accept, r_state != S_IDLE)

endmodule

### tb/sv/tb_generational_handle_allocator_unit.sv
`timescale 1ns / 1ps

module tb_generational_handle_allocator_unit;
    import ghau_pkg::*;

    localparam int SLOTS         = SLOTS_DEF;
    localparam int GEN_BITS      = GEN_BITS_DEF;
    localparam int REF_BITS      = REF_BITS_DEF;
    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int DRAIN_CYCLES  = 10;
    localparam int STALL_RUN_MAX = 8;
    localparam int NUM_DIR       = 25;
    localparam int REF_RUN       = 12;

    // Receiver backpressure patterns
    typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} t_rx_mode;

    // One directed row: request, plus a hand-written reply when typed is set
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [KIND_W-1:0]   kind;
        logic [TAG_W-1:0]    tag;
        logic                typed;
        logic [STATUS_W-1:0] status;
        logic [TAG_W-1:0]    new_tag;
        logic                freed;
        logic [LIVE_W-1:0]   live;
    } t_dir_row;

    // Tags below are index * 2^24 + generation
    localparam t_dir_row DIR_TABLE [NUM_DIR] = '{
        // nothing live yet: tag zero is never valid
        '{ACT_CHECK,   KIND_SHAPE,   34'h0,           1'b1, ST_INVALID,
          34'h0,           1'b0, 11'd0},
        // allocations with kinds outside shape..mesh
        '{ACT_ALLOC,   KIND_FREE,    34'h0,           1'b1, ST_WRONG_KIND,
          34'h0,           1'b0, 11'd0},
        '{ACT_ALLOC,   3'd7,         34'h0,           1'b1, ST_WRONG_KIND,
          34'h0,           1'b0, 11'd0},
        // fresh slots; slot 0 skips generation 0, tag field ignored
        '{ACT_ALLOC,   KIND_SHAPE,   34'h3_FFFF_FFFF, 1'b1, ST_OK,
          34'h0_0000_0001, 1'b0, 11'd1},
        '{ACT_ALLOC,   KIND_ENTITY,  34'h0,           1'b1, ST_OK,
          34'h0_0100_0000, 1'b0, 11'd2},
        '{ACT_ALLOC,   KIND_HISTORY, 34'h0,           1'b1, ST_OK,
          34'h0_0200_0000, 1'b0, 11'd3},
        '{ACT_ALLOC,   KIND_MESH,    34'h0,           1'b1, ST_OK,
          34'h0_0300_0000, 1'b0, 11'd4},
        // validation: good, wrong kind, past fresh mark, generation mismatch
        '{ACT_CHECK,   KIND_SHAPE,   34'h0_0000_0001, 1'b1, ST_OK,
          34'h0,           1'b0, 11'd4},
        '{ACT_CHECK,   KIND_ENTITY,  34'h0_0000_0001, 1'b1, ST_WRONG_KIND,
          34'h0,           1'b0, 11'd4},
        '{ACT_CHECK,   KIND_SHAPE,   34'h0_0400_0000, 1'b1, ST_INVALID,
          34'h0,           1'b0, 11'd4},
        '{ACT_CHECK,   KIND_SHAPE,   34'h0_0000_0002, 1'b1, ST_INVALID,
          34'h0,           1'b0, 11'd4},
        // only shapes carry a count
        '{ACT_ADD_REF, KIND_ENTITY,  34'h0_0100_0000, 1'b1, ST_WRONG_KIND,
          34'h0,           1'b0, 11'd4},
        '{ACT_ADD_REF, KIND_SHAPE,   34'h0_0000_0001, 1'b1, ST_OK,
          34'h0,           1'b0, 11'd4},
        // shape: count 2 -> 1, then freed; its old tag is stale afterwards
        '{ACT_RELEASE, KIND_SHAPE,   34'h0_0000_0001, 1'b1, ST_OK,
          34'h0,           1'b0, 11'd4},
        '{ACT_RELEASE, KIND_SHAPE,   34'h0_0000_0001, 1'b1, ST_OK,
          34'h0,           1'b1, 11'd3},
        '{ACT_RELEASE, KIND_SHAPE,   34'h0_0000_0001, 1'b1, ST_INVALID,
          34'h0,           1'b0, 11'd3},
        // entities stay; history and mesh go at once
        '{ACT_RELEASE, KIND_ENTITY,  34'h0_0100_0000, 1'b1, ST_NOT_RELEASABLE,
          34'h0,           1'b0, 11'd3},
        '{ACT_RELEASE, KIND_HISTORY, 34'h0_0200_0000, 1'b1, ST_OK,
          34'h0,           1'b1, 11'd2},
        '{ACT_RELEASE, KIND_MESH,    34'h0_0300_0000, 1'b1, ST_OK,
          34'h0,           1'b1, 11'd1},
        // matching generation on a free slot is still invalid
        '{ACT_CHECK,   KIND_MESH,    34'h0_0300_0001, 1'b1, ST_INVALID,
          34'h0,           1'b0, 11'd1},
        // reuse from the free stack, last freed first
        '{ACT_ALLOC,   KIND_SHAPE,   34'h0,           1'b0, ST_OK,
          34'h0,           1'b0, 11'd0},
        '{ACT_ALLOC,   KIND_MESH,    34'h0,           1'b0, ST_OK,
          34'h0,           1'b0, 11'd0},
        '{ACT_ALLOC,   KIND_HISTORY, 34'h0,           1'b0, ST_OK,
          34'h0,           1'b0, 11'd0},
        // largest tag, and a kind no slot can have
        '{ACT_CHECK,   KIND_HISTORY, 34'h3_FFFF_FFFF, 1'b1, ST_INVALID,
          34'h0,           1'b0, 11'd4},
        '{ACT_RELEASE, 3'd5,         34'h0_0000_0002, 1'b1, ST_WRONG_KIND,
          34'h0,           1'b0, 11'd4}
    };

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_word  i_in_word   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_word o_out_word;

    // Shadow slot table
    logic [KIND_W-1:0]   tbl_kind [SLOTS];
    logic [REF_BITS-1:0] tbl_refs [SLOTS];
    logic [GEN_BITS-1:0] tbl_gen  [SLOTS];
    int unsigned         freed_slots [SLOTS];
    int unsigned         freed_depth = 0;
    int unsigned         fresh_top   = 0;
    int unsigned         live_cnt    = 0;

    t_out_word   replies_due [$];
    t_out_word   due_reply;
    t_out_word   last_reply;
    int          mismatches = 0;
    int unsigned cycle_cnt  = 0;
    int          burst_left = 0;

    generational_handle_allocator_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb_generational_handle_allocator_unit: FAIL");
            $finish;
        end
    end

    // Receiver stall: the pattern is redrawn after each random span, runs are bounded
    initial begin : rx_stall
        t_rx_mode    mode;
        int unsigned span;
        int unsigned run;
        int unsigned phase;
        logic        hold;
        run   = 0;
        phase = 0;
        forever begin
            mode = t_rx_mode'($urandom_range(0, 3));
            span = $urandom_range(32, 200);
            repeat (span) begin
                @(negedge i_clk);
                phase++;
                case (mode)
                    RX_OPEN:     hold = 1'b0;
                    RX_LIGHT:    hold = ($urandom_range(0, 3) == 0);
                    RX_HEAVY:    hold = ($urandom_range(0, 9) < 6);
                    default:     hold = (phase % 3 != 0);
                endcase
                if (run >= STALL_RUN_MAX)
                    hold = 1'b0;
                run = hold ? run + 1 : 0;
                i_out_stall <= hold;
            end
        end
    end

    // Reply checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (replies_due.size() == 0) begin
                $error("reply word with no request outstanding");
                mismatches++;
            end else begin
                due_reply = replies_due.pop_front();
                if (o_out_word.status !== due_reply.status) begin
                    $error("status: expected %0d, actual %0d",
                           due_reply.status, o_out_word.status);
                    mismatches++;
                end
                if (o_out_word.new_tag !== due_reply.new_tag) begin
                    $error("new_tag: expected %h, actual %h",
                           due_reply.new_tag, o_out_word.new_tag);
                    mismatches++;
                end
                if (o_out_word.slot_freed !== due_reply.slot_freed) begin
                    $error("slot_freed: expected %0d, actual %0d",
                           due_reply.slot_freed, o_out_word.slot_freed);
                    mismatches++;
                end
                if (o_out_word.live_handles !== due_reply.live_handles) begin
                    $error("live_handles: expected %0d, actual %0d",
                           due_reply.live_handles, o_out_word.live_handles);
                    mismatches++;
                end
            end
        end
    end

    // Applies one request to the shadow table and returns the reply it earns
    function automatic t_out_word predict_reply(input t_in_word req);
        t_out_word        rep;
        int unsigned      s;
        logic [TAG_W-1:0] idx;
        rep = '0;
        s   = 0;
        if (req.action == ACT_ALLOC) begin
            if (req.kind < KIND_SHAPE || req.kind > KIND_MESH) begin
                rep.status = ST_WRONG_KIND;
            end else if (freed_depth > 0) begin
                freed_depth--;
                s = freed_slots[freed_depth];
            end else if (fresh_top < SLOTS) begin
                s = fresh_top;
                fresh_top++;
            end else begin
                rep.status = ST_EXHAUSTED;
            end
            if (rep.status == ST_OK) begin
                tbl_kind[s] = req.kind;
                tbl_refs[s] = REF_BITS'(1);
                if (s == 0 && tbl_gen[s] == 0)
                    tbl_gen[s] = GEN_BITS'(1);
                live_cnt++;
                rep.new_tag = (TAG_W'(s) << GEN_BITS) | TAG_W'(tbl_gen[s]);
            end
        end else begin
            // tag validation, then kind
            idx = req.handle_tag >> GEN_BITS;
            if (req.handle_tag == '0 || idx >= fresh_top) begin
                rep.status = ST_INVALID;
            end else begin
                s = int'(idx);
                if (tbl_gen[s] != req.handle_tag[GEN_BITS-1:0] || tbl_kind[s] == KIND_FREE)
                    rep.status = ST_INVALID;
                else if (tbl_kind[s] != req.kind)
                    rep.status = ST_WRONG_KIND;
            end
            if (rep.status == ST_OK) begin
                case (req.action)
                    ACT_ADD_REF: begin
                        if (req.kind != KIND_SHAPE)
                            rep.status = ST_WRONG_KIND;
                        else if (tbl_refs[s] == '1)
                            rep.status = ST_SATURATED;
                        else
                            tbl_refs[s]++;
                    end
                    ACT_RELEASE: begin
                        if (req.kind == KIND_ENTITY) begin
                            rep.status = ST_NOT_RELEASABLE;
                        end else if (req.kind == KIND_SHAPE && tbl_refs[s] > 1) begin
                            tbl_refs[s]--;
                        end else begin
                            // free: bump generation, push onto the free stack
                            tbl_kind[s] = KIND_FREE;
                            tbl_refs[s] = '0;
                            tbl_gen[s]  = tbl_gen[s] + 1'b1;
                            if (s == 0 && tbl_gen[s] == 0)
                                tbl_gen[s] = GEN_BITS'(1);
                            if (freed_depth < SLOTS) begin
                                freed_slots[freed_depth] = s;
                                freed_depth++;
                            end
                            if (live_cnt > 0)
                                live_cnt--;
                            rep.slot_freed = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
        rep.live_handles = LIVE_W'(live_cnt);
        return rep;
    endfunction

    // Random request, mostly aimed at live slots with the right kind
    function automatic t_in_word pick_request();
        t_in_word    r;
        int unsigned roll;
        int unsigned aim;
        int unsigned s;
        int unsigned tries;
        roll         = $urandom_range(0, 99);
        r.handle_tag = TAG_W'({$urandom, $urandom});
        r.kind       = KIND_W'($urandom_range(1, 4));
        if (roll < 30)
            r.action = ACT_ALLOC;
        else if (roll < 50)
            r.action = ACT_CHECK;
        else if (roll < 70)
            r.action = ACT_ADD_REF;
        else
            r.action = ACT_RELEASE;

        if (r.action == ACT_ALLOC) begin
            if ($urandom_range(0, 19) == 0)
                r.kind = KIND_W'($urandom_range(0, 7));
        end else begin
            aim = $urandom_range(0, 99);
            if (aim < 85 && fresh_top > 0) begin
                s     = $urandom_range(0, fresh_top - 1);
                tries = 0;
                while (tries < 8 && (tbl_kind[s] == KIND_FREE ||
                       (r.action == ACT_ADD_REF && tbl_kind[s] != KIND_SHAPE))) begin
                    s = $urandom_range(0, fresh_top - 1);
                    tries++;
                end
                r.handle_tag = (TAG_W'(s) << GEN_BITS) | TAG_W'(tbl_gen[s]);
                if (tbl_kind[s] != KIND_FREE)
                    r.kind = tbl_kind[s];
                if (aim < 8) begin
                    r.kind = KIND_W'($urandom_range(0, 7));
                end else if (aim < 14) begin
                    // stale generation
                    r.handle_tag = (TAG_W'(s) << GEN_BITS) |
                                   TAG_W'(GEN_BITS'(tbl_gen[s] - 1'b1));
                end
            end else begin
                r.kind = KIND_W'($urandom_range(0, 7));
            end
        end
        return r;
    endfunction

    // Offers one word, waits for it to be taken, records the reply it is owed
    task automatic push_request(input t_in_word req, input bit bursty, input bit typed,
                                input t_out_word typed_reply, output t_out_word reply);
        int unsigned gap;
        i_in_valid <= 1'b1;
        i_in_word  <= req;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0)
            @(posedge i_clk);
        reply = predict_reply(req);
        replies_due = {replies_due, (typed ? typed_reply : reply)};
        @(negedge i_clk);
        if (bursty) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                gap = $urandom_range(0, 5);
                if (gap > 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
                burst_left = $urandom_range(0, 15);
            end
        end
    endtask

    // Sender holds off until every owed reply has come back
    task automatic wait_replies_drained();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (replies_due.size() != 0);
    endtask

    initial begin : stimulus
        t_in_word         req;
        t_out_word        typed_reply;
        logic [TAG_W-1:0] ref_tag;
        int               i;

        for (i = 0; i < SLOTS; i++) begin
            tbl_kind[i]    = KIND_FREE;
            tbl_refs[i]    = '0;
            tbl_gen[i]     = '0;
            freed_slots[i] = 0;
        end

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table
        for (i = 0; i < NUM_DIR; i++) begin
            req.action     = DIR_TABLE[i].action;
            req.kind       = DIR_TABLE[i].kind;
            req.handle_tag = DIR_TABLE[i].tag;
            typed_reply    = '{DIR_TABLE[i].status, DIR_TABLE[i].new_tag,
                               DIR_TABLE[i].freed, DIR_TABLE[i].live};
            push_request(req, 1'b1, DIR_TABLE[i].typed, typed_reply, last_reply);
        end

        // Random mix
        repeat (300) push_request(pick_request(), 1'b1, 1'b0, '0, last_reply);
        wait_replies_drained();

        // One shape counted up, then released down to free, no gaps
        req.action     = ACT_ALLOC;
        req.kind       = KIND_SHAPE;
        req.handle_tag = '0;
        push_request(req, 1'b0, 1'b0, '0, last_reply);
        ref_tag        = last_reply.new_tag;
        req.action     = ACT_ADD_REF;
        req.handle_tag = ref_tag;
        repeat (REF_RUN) push_request(req, 1'b0, 1'b0, '0, last_reply);
        req.action = ACT_RELEASE;
        repeat (REF_RUN + 1) push_request(req, 1'b0, 1'b0, '0, last_reply);

        // Churn
        repeat (200) push_request(pick_request(), 1'b1, 1'b0, '0, last_reply);

        wait_replies_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb_generational_handle_allocator_unit: PASS");
        else
            $display("tb_generational_handle_allocator_unit: FAIL");
        $finish;
    end

endmodule
